/* rtl/sgti_pkg.sv */
// Shared types and constants of the sphere grid triangle index generator.
// No dependencies; imported by the top level.
package sgti_pkg;

	// Vertex index and counter widths
	localparam int IDX_W     = 20;
	localparam int ROW_W     = 10;
	localparam int REG_W     = 11;
	localparam int CFG_IDX_W = 2;

	// Stream payload widths (whole bytes)
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 64;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SLICE_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_STACK_COUNT = CFG_IDX_W'(1);

	// Region code carried on tuser
	typedef enum logic [1:0] {
		REGION_TOP = 2'd0,
		REGION_MID = 2'd1,
		REGION_BOT = 2'd2
	} region_t;

	// One triangle as it sits in the output registers
	typedef struct packed {
		logic              last_triangle;
		region_t           region;
		logic [IDX_W-1:0]  vertex_c;
		logic [IDX_W-1:0]  vertex_b;
		logic [IDX_W-1:0]  vertex_a;
	} tri_t;

endpackage

/* rtl/sphere_grid_triangle_index_generator.sv */
// Triangle index stream of a latitude-longitude sphere grid: top fan, middle strips, bottom fan.
// Depends on sgti_pkg.
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata[0] restart
//  m_axis    out  m_axis_tvalid/tready      tdata a,b,c; tuser region; tlast last triangle
//  cfg       in   cfg_valid/cfg_ready       cfg_index, cfg_data (0 slice_count, 1 stack_count)
//
// One triangle per input transfer; a new transfer is taken while older results wait, until
// both output entries are full. Each result is registered in the output or skid register.
// Reset loads 32 slices, 16 stacks and the first top-fan triangle; no clearing pass.
// A two-entry output stage (output register plus skid register) lets s_axis_tready depend on
// registered state only; input stalls only when both entries hold results.
// A configuration write to slice_count or stack_count restarts the sequence with the new counts.
module sphere_grid_triangle_index_generator #(
	parameter int MAX_SLICES = 1024,
	parameter int MAX_STACKS = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input stream
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [sgti_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // [0] restart, [7:1] zero
	// output stream
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [sgti_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // [19:0] a, [39:20] b, [59:40] c
	output logic [1:0]                          m_axis_tuser,   // [1:0] region
	output logic                                m_axis_tlast,   // last triangle of the sphere
	// configuration writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sgti_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sgti_pkg::REG_W-1:0]          cfg_data
);
	import sgti_pkg::*;

	localparam int SW = $clog2(MAX_SLICES + 1);
	localparam int TW = $clog2(MAX_STACKS + 1);
	localparam int PW = SW + TW;
	localparam int S_RST = (32 > MAX_SLICES) ? MAX_SLICES : 32;
	localparam int T_RST = (16 > MAX_STACKS) ? MAX_STACKS : 16;
	localparam int POLE_RST = (1 + (T_RST - 1) * S_RST) % (1 << IDX_W);

	typedef enum logic [1:0] {
		PH_TOP = 2'd0,
		PH_MID = 2'd1,
		PH_BOT = 2'd2
	} phase_t;

	// Effective counts and derived pole index
	logic [SW-1:0]    s_eff_q;
	logic [TW-1:0]    t_eff_q;
	logic [IDX_W-1:0] pole_q;

	// Sequence state
	phase_t           phase_q;
	logic [ROW_W-1:0] row_q;
	logic [SW-1:0]    col_q;
	logic             pair_q;
	logic [IDX_W-1:0] upper_q;
	logic [IDX_W-1:0] lower_q;

	// Output stage
	tri_t             out_q;
	tri_t             skid_q;
	logic             out_valid_q;
	logic             skid_valid_q;

	logic             in_xfer;
	logic             out_xfer;
	logic             cfg_hit;

	// Config write datapath
	logic [31:0]      cfg_raw;
	logic [31:0]      sat_s;
	logic [31:0]      sat_t;
	logic [SW-1:0]    new_s;
	logic [TW-1:0]    new_t;
	logic [PW-1:0]    new_prod;
	logic [IDX_W-1:0] new_pole;

	// Step datapath
	logic             do_rst;
	phase_t           st_phase;
	logic [SW-1:0]    st_col;
	logic             st_pair;
	logic [ROW_W-1:0] st_row;
	logic [IDX_W-1:0] st_upper;
	logic [IDX_W-1:0] st_lower;
	logic [IDX_W-1:0] lower_init;
	logic [SW-1:0]    s_m1;
	logic [SW-1:0]    col;
	logic             col_last;
	logic [SW-1:0]    col_nxt;
	logic [IDX_W-1:0] col_i;
	logic [IDX_W-1:0] nxt_i;
	logic             row_last;

	phase_t           n_phase;
	logic [ROW_W-1:0] n_row;
	logic [SW-1:0]    n_col;
	logic             n_pair;
	logic [IDX_W-1:0] n_upper;
	logic [IDX_W-1:0] n_lower;
	tri_t             n_tri;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_xfer = out_valid_q && m_axis_tready;
	assign cfg_hit  = cfg_valid && ((cfg_index == REG_SLICE_COUNT) ||
		(cfg_index == REG_STACK_COUNT));

	// Saturate the written count and form the bottom pole index
	always_comb begin
		cfg_raw = 32'(cfg_data);
		sat_s = cfg_raw;
		if (cfg_raw < 32'd3) sat_s = 32'd3;
		else if (cfg_raw > 32'(MAX_SLICES)) sat_s = 32'(MAX_SLICES);
		sat_t = cfg_raw;
		if (cfg_raw < 32'd2) sat_t = 32'd2;
		else if (cfg_raw > 32'(MAX_STACKS)) sat_t = 32'(MAX_STACKS);
		new_s = (cfg_valid && cfg_index == REG_SLICE_COUNT) ? SW'(sat_s) : s_eff_q;
		new_t = (cfg_valid && cfg_index == REG_STACK_COUNT) ? TW'(sat_t) : t_eff_q;
		new_prod = PW'(new_t - TW'(1)) * PW'(new_s);
		new_pole = IDX_W'(new_prod) + IDX_W'(1);
	end

	// One triangle and the next sequence state
	always_comb begin
		do_rst = s_axis_tdata[0] ||
			!((phase_q == PH_TOP) || (phase_q == PH_MID) || (phase_q == PH_BOT));
		lower_init = IDX_W'(s_eff_q) + IDX_W'(1);
		st_phase = do_rst ? PH_TOP : phase_q;
		st_col   = do_rst ? '0 : col_q;
		st_pair  = do_rst ? 1'b0 : pair_q;
		st_row   = do_rst ? '0 : row_q;
		st_upper = do_rst ? IDX_W'(1) : upper_q;
		st_lower = do_rst ? lower_init : lower_q;

		s_m1     = s_eff_q - SW'(1);
		col      = (st_col >= s_eff_q) ? s_m1 : st_col;
		col_last = (col == s_m1);
		col_nxt  = col_last ? '0 : col + SW'(1);
		col_i    = IDX_W'(col);
		nxt_i    = IDX_W'(col_nxt);
		row_last = (32'(st_row) + 32'd1) >= (32'(t_eff_q) - 32'd2);

		n_phase = st_phase;
		n_row   = st_row;
		n_col   = st_col;
		n_pair  = st_pair;
		n_upper = st_upper;
		n_lower = st_lower;
		n_tri   = '0;

		case (st_phase)
			PH_TOP: begin
				n_tri.region   = REGION_TOP;
				n_tri.vertex_a = '0;
				if (!col_last) begin
					n_tri.vertex_b = col_i + IDX_W'(1);
					n_tri.vertex_c = col_i + IDX_W'(2);
					n_col = col + SW'(1);
				end else begin
					n_tri.vertex_b = IDX_W'(s_eff_q);
					n_tri.vertex_c = IDX_W'(1);
					n_col = '0;
					n_phase = (32'(t_eff_q) > 32'd2) ? PH_MID : PH_BOT;
				end
			end
			PH_MID: begin
				n_tri.region   = REGION_MID;
				n_tri.vertex_a = st_lower + col_i;
				if (!st_pair) begin
					n_tri.vertex_b = st_lower + nxt_i;
					n_tri.vertex_c = st_upper + nxt_i;
					n_pair = 1'b1;
				end else begin
					n_tri.vertex_b = st_upper + nxt_i;
					n_tri.vertex_c = st_upper + col_i;
					n_pair = 1'b0;
					n_col = col_nxt;
					// ring closed: next row or bottom fan
					if (col_last) begin
						if (row_last) begin
							n_row = '0;
							n_phase = PH_BOT;
						end else begin
							n_row = st_row + ROW_W'(1);
							n_upper = st_lower;
							n_lower = st_lower + IDX_W'(s_eff_q);
						end
					end
				end
			end
			PH_BOT: begin
				n_tri.region   = REGION_BOT;
				n_tri.vertex_a = pole_q;
				if (!col_last) begin
					n_tri.vertex_b = pole_q - IDX_W'(1) - col_i;
					n_tri.vertex_c = pole_q - IDX_W'(2) - col_i;
					n_col = col + SW'(1);
				end else begin
					n_tri.vertex_b = pole_q - IDX_W'(s_eff_q);
					n_tri.vertex_c = pole_q - IDX_W'(1);
					n_tri.last_triangle = 1'b1;
					// wrap to the first top-fan triangle
					n_phase = PH_TOP;
					n_col   = '0;
					n_pair  = 1'b0;
					n_row   = '0;
					n_upper = IDX_W'(1);
					n_lower = lower_init;
				end
			end
			default: begin
				n_phase = PH_TOP;
			end
		endcase
	end

	// Configuration and sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_eff_q <= SW'(S_RST);
			t_eff_q <= TW'(T_RST);
			pole_q  <= IDX_W'(POLE_RST);
			phase_q <= PH_TOP;
			row_q   <= '0;
			col_q   <= '0;
			pair_q  <= 1'b0;
			upper_q <= IDX_W'(1);
			lower_q <= IDX_W'(S_RST + 1);
		end else if (cfg_hit) begin
			s_eff_q <= new_s;
			t_eff_q <= new_t;
			pole_q  <= new_pole;
			phase_q <= PH_TOP;
			row_q   <= '0;
			col_q   <= '0;
			pair_q  <= 1'b0;
			upper_q <= IDX_W'(1);
			lower_q <= IDX_W'(new_s) + IDX_W'(1);
		end else if (in_xfer) begin
			phase_q <= n_phase;
			row_q   <= n_row;
			col_q   <= n_col;
			pair_q  <= n_pair;
			upper_q <= n_upper;
			lower_q <= n_lower;
		end
	end

	// Output register and skid register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_xfer || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_xfer;
			end
		end else if (in_xfer) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (out_xfer || !out_valid_q) begin
			if (skid_valid_q) out_q <= skid_q;
			else if (in_xfer) out_q <= n_tri;
		end else if (in_xfer) begin
			skid_q <= n_tri;
		end
	end

	assign s_axis_tready = !skid_valid_q;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_DATA_W - 3 * IDX_W)'(0), out_q.vertex_c, out_q.vertex_b,
		out_q.vertex_a};
	assign m_axis_tuser  = out_q.region;
	assign m_axis_tlast  = out_q.last_triangle;

	// Skid entry is only used behind a full output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds data while output register is empty");

	// An accepted item with free output space shows up on the next cycle
	a_accept_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && !skid_valid_q && (!out_valid_q || out_xfer)) |=> m_axis_tvalid)
		else $error("accepted triangle did not reach the output register");

	// Column counter stays inside the ring
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q < s_eff_q)
		else $error("column counter beyond slice count");

	// Final triangle belongs to the bottom fan
	a_last_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == REGION_BOT))
		else $error("last triangle outside the bottom fan");

	// Top-fan triangles are anchored at the top pole
	a_top_pole: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == REGION_TOP) |-> (m_axis_tdata[IDX_W-1:0] == '0))
		else $error("top-fan triangle not anchored at vertex zero");

endmodule

/* sim/tb.sv */
// Self-checking bench for the sphere grid triangle index generator.
// Depends on sgti_pkg and sphere_grid_triangle_index_generator; a scoreboard class
// tracks the grid walk and checks every triangle transfer on the master side.
`timescale 1ns / 100ps

module tb;
	import sgti_pkg::*;

	localparam int SLICE_CAP = 1024;
	localparam int STACK_CAP = 1024;
	localparam int CYCLE_LIMIT = 300000;
	localparam logic [IDX_W-1:0] IDX_MASK = '1;

	// register indexes that the block does not decode
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

	// Scoreboard: own copy of the counts and the walk state, queue of triangles due
	class triangle_board;
		logic [REG_W-1:0] slice_reg;
		logic [REG_W-1:0] stack_reg;
		region_t          ph;
		int unsigned      row;
		int unsigned      col_cnt;
		int unsigned      upper_base;
		int unsigned      lower_base;
		int unsigned      pole;
		bit               second;
		tri_t             due_tris[$];
		int               mismatches;

		function new();
			slice_reg  = REG_W'(32);
			stack_reg  = REG_W'(16);
			mismatches = 0;
			rewind();
		endfunction

		function int unsigned slices();
			int unsigned s;
			s = slice_reg;
			if (s < 3) s = 3;
			if (s > SLICE_CAP) s = SLICE_CAP;
			return s;
		endfunction

		function int unsigned stacks();
			int unsigned t;
			t = stack_reg;
			if (t < 2) t = 2;
			if (t > STACK_CAP) t = STACK_CAP;
			return t;
		endfunction

		// back to the first top-fan triangle with the current counts
		function void rewind();
			int unsigned s;
			int unsigned t;
			s = slices();
			t = stacks();
			ph         = REGION_TOP;
			row        = 0;
			col_cnt    = 0;
			second     = 1'b0;
			upper_base = 1;
			lower_base = (s + 1) & IDX_MASK;
			pole       = (1 + (t - 1) * s) & IDX_MASK;
		endfunction

		// register write; unknown indexes leave everything alone
		function void write_count(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
			case (idx)
				REG_SLICE_COUNT: begin
					slice_reg = val;
					rewind();
				end
				REG_STACK_COUNT: begin
					stack_reg = val;
					rewind();
				end
				default: ;
			endcase
		endfunction

		// one accepted tick: work out the triangle it emits
		function void step_grid(bit restart);
			int unsigned s;
			int unsigned t;
			int unsigned col;
			int unsigned nxt;
			int unsigned a;
			int unsigned b;
			int unsigned c;
			tri_t        e;
			if (restart) rewind();
			s = slices();
			t = stacks();
			col = (col_cnt >= s) ? s - 1 : col_cnt;
			e.last_triangle = 1'b0;
			e.region = ph;
			case (ph)
				REGION_TOP: begin
					a = 0;
					if (col < s - 1) begin
						b = col + 1;
						c = col + 2;
					end else begin
						b = s;
						c = 1;
					end
					if (col + 1 >= s) begin
						col_cnt = 0;
						ph = (t > 2) ? REGION_MID : REGION_BOT;
					end else begin
						col_cnt = col + 1;
					end
				end
				REGION_MID: begin
					nxt = (col + 1 >= s) ? 0 : col + 1;
					a = lower_base + col;
					if (!second) begin
						b = lower_base + nxt;
						c = upper_base + nxt;
						second = 1'b1;
					end else begin
						b = upper_base + nxt;
						c = upper_base + col;
						second = 1'b0;
						if (col + 1 >= s) begin
							col_cnt = 0;
							if (row + 1 >= t - 2) begin
								row = 0;
								ph = REGION_BOT;
							end else begin
								row = (row + 1) & 10'h3FF;
								upper_base = lower_base;
								lower_base = (lower_base + s) & IDX_MASK;
							end
						end else begin
							col_cnt = col + 1;
						end
					end
				end
				default: begin
					a = pole;
					if (col < s - 1) begin
						b = pole - 1 - col;
						c = pole - 2 - col;
						col_cnt = col + 1;
					end else begin
						b = pole - s;
						c = pole - 1;
						e.last_triangle = 1'b1;
						rewind();
					end
				end
			endcase
			e.vertex_a = a[IDX_W-1:0];
			e.vertex_b = b[IDX_W-1:0];
			e.vertex_c = c[IDX_W-1:0];
			due_tris = {due_tris, e};
		endfunction

		function void flag(string what);
			mismatches++;
			if (mismatches <= 10) $display("MISMATCH %s", what);
		endfunction

		// compare one output transfer with the oldest triangle due
		function void match_triangle(tri_t got);
			tri_t e;
			if (due_tris.size() == 0) begin
				flag($sformatf("unexpected triangle a=%0d b=%0d c=%0d region=%0d last=%0d",
					got.vertex_a, got.vertex_b, got.vertex_c, got.region, got.last_triangle));
				return;
			end
			e = due_tris.pop_front();
			if (got.vertex_a !== e.vertex_a || got.vertex_b !== e.vertex_b ||
			    got.vertex_c !== e.vertex_c || got.region !== e.region ||
			    got.last_triangle !== e.last_triangle)
				flag($sformatf({"exp a=%0d b=%0d c=%0d region=%0d last=%0d, ",
					"got a=%0d b=%0d c=%0d region=%0d last=%0d"},
					e.vertex_a, e.vertex_b, e.vertex_c, e.region, e.last_triangle,
					got.vertex_a, got.vertex_b, got.vertex_c, got.region, got.last_triangle));
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [1:0]            m_axis_tuser;
	logic                  m_axis_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [REG_W-1:0]      cfg_data = '0;

	triangle_board sb;
	int  tx_idle = 0;
	int  rx_idle = 0;
	bit  rx_hold = 1'b0;
	int  cycles = 0;

	sphere_grid_triangle_index_generator #(
		.MAX_SLICES(SLICE_CAP),
		.MAX_STACKS(STACK_CAP)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver: random backpressure, or a long hold-off when asked
	always @(posedge clk) begin
		if (rx_hold)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(99) >= rx_idle);
	end

	// input transfers feed the scoreboard
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			sb.step_grid(s_axis_tdata[0]);
	end

	// output transfers are checked
	always @(posedge clk) begin
		tri_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.vertex_a      = m_axis_tdata[IDX_W-1:0];
			got.vertex_b      = m_axis_tdata[2*IDX_W-1:IDX_W];
			got.vertex_c      = m_axis_tdata[3*IDX_W-1:2*IDX_W];
			got.region        = region_t'(m_axis_tuser);
			got.last_triangle = m_axis_tlast;
			sb.match_triangle(got);
		end
	end

	// offer one tick, with random gaps before it, and wait for its transfer
	task automatic send_tick(bit restart);
		while (tx_idle > 0 && $urandom_range(99) < tx_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_DATA_W-1){1'b0}}, restart};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// let the last input transfer reach the queue, then wait for every due triangle to come out
	task automatic drain();
		@(posedge clk);
		while (sb.due_tris.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register write, only once every triangle has come out
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
		s_axis_tvalid <= 1'b0;
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_count(idx, val);
		cfg_valid <= 1'b0;
	endtask

	// random counts, mostly tiny spheres so the walk wraps often
	task automatic run_section(int tx_pct, int rx_pct, int quota);
		int          sent;
		int          n;
		int unsigned s;
		int unsigned t;
		tx_idle = tx_pct;
		rx_idle = rx_pct;
		sent = 0;
		while (sent < quota) begin
			case ($urandom_range(9))
				0: begin
					s = $urandom_range(0, 2047);
					t = $urandom_range(0, 2047);
				end
				1: begin
					s = SLICE_CAP;
					t = $urandom_range(0, 3);
				end
				default: begin
					s = $urandom_range(3, 10);
					t = $urandom_range(2, 8);
				end
			endcase
			write_reg(REG_SLICE_COUNT, REG_W'(s));
			write_reg(REG_STACK_COUNT, REG_W'(t));
			if ($urandom_range(7) == 0)
				write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3,
					REG_W'($urandom_range(0, 2047)));
			n = $urandom_range(40, 90);
			repeat (n) send_tick($urandom_range(29) == 0);
			sent += n;
		end
	endtask

	initial begin
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset counts, restart at once and twice in a row
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b1);
		// smallest sphere: two stacks, bottom fan right after top fan, wrap
		write_reg(REG_SLICE_COUNT, REG_W'(3));
		write_reg(REG_STACK_COUNT, REG_W'(2));
		repeat (8) send_tick(1'b0);
		// counts below range saturate up
		write_reg(REG_SLICE_COUNT, REG_W'(0));
		write_reg(REG_STACK_COUNT, REG_W'(0));
		repeat (3) send_tick(1'b0);
		// counts above range saturate down
		write_reg(REG_SLICE_COUNT, REG_W'(2047));
		write_reg(REG_STACK_COUNT, REG_W'(2047));
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		// unused indexes must not restart the walk
		write_reg(REG_SPARE_2, REG_W'(11'h555));
		write_reg(REG_SPARE_3, REG_W'(11'h2AA));
		send_tick(1'b0);
		send_tick(1'b0);

		// random part
		run_section(31, 52, 300);
		run_section(52, 31, 300);
		tx_idle = 0;
		rx_idle = 0;
		// long receiver hold-off while ticks keep coming
		write_reg(REG_SLICE_COUNT, REG_W'(32));
		write_reg(REG_STACK_COUNT, REG_W'(16));
		fork
			begin
				rx_hold <= 1'b1;
				repeat (400) @(posedge clk);
				rx_hold <= 1'b0;
			end
		join_none
		repeat (80) send_tick(1'b0);
		run_section(0, 0, 300);

		s_axis_tvalid <= 1'b0;
		drain();
		repeat (20) @(posedge clk);
		if (sb.due_tris.size() != 0)
			sb.flag($sformatf("%0d triangles never came out", sb.due_tris.size()));
		if (sb.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
